// File: design/strip_plane_active_area_and_strip_top_macros.svh
// Assertion helpers for the plane distance and strip block.
`ifndef STRIP_PLANE_ACTIVE_AREA_AND_STRIP_TOP_MACROS_SVH
`define STRIP_PLANE_ACTIVE_AREA_AND_STRIP_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPAA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPAA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/spaa_pkg.sv
`default_nettype none
package spaa_pkg;

    localparam int DIST_W     = 20;
    localparam int DW_W       = 18;
    localparam int GAP_W      = 16;
    localparam int NS_W       = 11;
    localparam int ND_W       = 4;
    localparam int IDX_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int PER_W      = 19;
    localparam int HALF_W     = 22;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int ROOT_W     = DIST_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int PROD_W     = DW_W + NS_W;
    localparam int DIST_MIN   = -(2 ** (DIST_W - 1));

    localparam int MAX_DIES_DEF    = 8;
    localparam int MAX_STRIPS_DEF  = 1024;
    localparam int COORD_WIDTH_DEF = 19;

    localparam logic [DW_W-1:0]  DIE_WIDTH_RST = 18'd91648;
    localparam logic [GAP_W-1:0] GUARD_RST     = 16'd997;
    localparam logic [GAP_W-1:0] GAP_Y_RST     = 16'd26;
    localparam logic [GAP_W-1:0] GAP_X_RST     = 16'd205;
    localparam logic [NS_W-1:0]  STRIPS_RST    = 11'd384;
    localparam logic [ND_W-1:0]  DIES_RST      = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIE_WIDTH = 3'd0,
        REG_GUARD     = 3'd1,
        REG_GAP_Y     = 3'd2,
        REG_GAP_X     = 3'd3,
        REG_STRIPS    = 3'd4,
        REG_DIES      = 3'd5
    } cfg_reg_t;

    function automatic logic [PER_W:0] div_step(input logic [PER_W-1:0] r,
                                                input logic b,
                                                input logic [PER_W-1:0] d);
        logic [PER_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
            return {1'b1, PER_W'(t - {1'b0, d})};
        return {1'b0, t[PER_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// File: design/strip_plane_active_area_and_strip_top.sv
// Pipeline: input register, divider stages, axis, square and sum registers,
//   square-root stages and output register, all advancing on one shared enable.
// Throughput: one word per cycle; the whole pipeline halts while a finished
//   word waits at the output.
// Reset: rst_n asynchronous, active low; clears all valid bits and loads the
//   default geometry into the configuration registers.
`default_nettype none
`include "strip_plane_active_area_and_strip_top_macros.svh"
module strip_plane_active_area_and_strip_top
    import spaa_pkg::*;
#(
    parameter int MAX_DIES           = MAX_DIES_DEF,
    parameter int MAX_STRIPS_PER_DIE = MAX_STRIPS_DEF,
    parameter int COORD_WIDTH        = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] x_pos,
    input  wire logic signed [COORD_WIDTH-1:0] y_pos,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [DIST_W-1:0]           dist_x,
    output logic signed [DIST_W-1:0]           dist_y,
    output logic signed [DIST_W-1:0]           dist_plane,
    output logic [IDX_W-1:0]                   strip_index,
    output logic                               strip_valid,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int U_W      = ((COORD_WIDTH > HALF_W) ? COORD_WIDTH : HALF_W) + 2;
    localparam int Q_W      = U_W - 1;
    localparam int NDC_W    = $clog2(MAX_DIES + 1);
    localparam int NS_CAP   = (MAX_STRIPS_PER_DIE > 2 ** NS_W - 1) ?
                              2 ** NS_W - 1 : MAX_STRIPS_PER_DIE;
    localparam int IT       = ROOT_W;
    localparam int SD_STEPS = NS_W;

    typedef struct packed {
        logic                  valid;
        logic signed [U_W-1:0] ux;
        logic signed [U_W-1:0] uy;
        logic [PER_W-1:0]      rx;
        logic [PER_W-1:0]      ry;
        logic [Q_W-1:0]        qx;
    } div_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DIST_W-1:0] dx;
        logic signed [DIST_W-1:0] dy;
        logic signed [DIST_W-1:0] w;
        logic [NDC_W-1:0]         die;
        logic                     strip_en;
    } axis_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DIST_W-1:0] dx;
        logic signed [DIST_W-1:0] dy;
        logic [SQ_W-1:0]          sqx;
        logic [SQ_W-1:0]          sqy;
        logic [PROD_W-1:0]        prod;
        logic                     neg;
        logic signed [DIST_W-1:0] dmin;
        logic [NDC_W-1:0]         die;
        logic                     strip_en;
    } sq_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DIST_W-1:0] dx;
        logic signed [DIST_W-1:0] dy;
        logic [SQ_W-1:0]          sum;
        logic [PROD_W-1:0]        prod;
        logic                     neg;
        logic signed [DIST_W-1:0] dmin;
        logic [NDC_W-1:0]         die;
        logic                     strip_en;
    } sum_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DIST_W-1:0] dx;
        logic signed [DIST_W-1:0] dy;
        logic [SQ_W-1:0]          sum;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic [PROD_W-1:0]        prod;
        logic [DW_W-1:0]          sr;
        logic [NS_W-1:0]          sq;
        logic                     neg;
        logic signed [DIST_W-1:0] dmin;
        logic [NDC_W-1:0]         die;
        logic                     strip_en;
    } iter_t;

    function automatic logic signed [DIST_W-1:0] axis_dist(
        input logic signed [U_W-1:0] u,
        input logic [PER_W-1:0]      e,
        input logic [DW_W-1:0]       dw,
        input logic [GAP_W-1:0]      g
    );
        logic [DW_W-1:0] ef;
        if (u < 0)
        begin
            if (u < DIST_MIN)
                return DIST_W'(DIST_MIN);
            return DIST_W'(u);
        end
        if (e > PER_W'(dw))
            return -DIST_W'(e);
        if ({e, 1'b0} > {2'b00, dw})
            ef = dw - DW_W'(e);
        else
            ef = DW_W'(e);
        return DIST_W'(ef) - DIST_W'(g);
    endfunction

    logic [DW_W-1:0]  die_width_reg;
    logic [GAP_W-1:0] guard_reg;
    logic [GAP_W-1:0] gap_y_reg;
    logic [GAP_W-1:0] gap_x_reg;
    logic [NS_W-1:0]  strips_reg;
    logic [ND_W-1:0]  dies_reg;

    logic [DW_W-1:0]   dw_eff;
    logic [NDC_W-1:0]  nd_eff;
    logic [NS_W-1:0]   ns_eff;
    logic [PER_W-1:0]  period_x;
    logic [PER_W-1:0]  period_y;
    logic [23:0]       panel;
    logic [HALF_W-1:0] half;
    logic              strip_cfg_ok;
    logic [DW_W-1:0]   den;

    logic en;

    logic                  s0_valid_reg;
    logic signed [U_W-1:0] s0_ux_reg;
    logic signed [U_W-1:0] s0_uy_reg;
    logic signed [U_W-1:0] ux_next;
    logic signed [U_W-1:0] uy_next;

    div_t  div_in   [Q_W];
    div_t  div_next [Q_W];
    div_t  div_reg  [Q_W];
    axis_t a_next;
    axis_t a_reg;
    sq_t   b_next;
    sq_t   b_reg;
    sum_t  c_next;
    sum_t  c_reg;
    iter_t it_in   [IT];
    iter_t it_next [IT];
    iter_t it_reg  [IT];

    logic                     out_valid_reg;
    logic signed [DIST_W-1:0] dist_x_reg;
    logic signed [DIST_W-1:0] dist_y_reg;
    logic signed [DIST_W-1:0] dist_plane_reg;
    logic [IDX_W-1:0]         strip_index_reg;
    logic                     strip_valid_reg;
    logic signed [DIST_W-1:0] dist_plane_next;
    logic [IDX_W-1:0]         strip_index_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            die_width_reg <= DIE_WIDTH_RST;
            guard_reg     <= GUARD_RST;
            gap_y_reg     <= GAP_Y_RST;
            gap_x_reg     <= GAP_X_RST;
            strips_reg    <= STRIPS_RST;
            dies_reg      <= DIES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIE_WIDTH: die_width_reg <= cfg_data[DW_W-1:0];
                REG_GUARD:     guard_reg     <= cfg_data[GAP_W-1:0];
                REG_GAP_Y:     gap_y_reg     <= cfg_data[GAP_W-1:0];
                REG_GAP_X:     gap_x_reg     <= cfg_data[GAP_W-1:0];
                REG_STRIPS:    strips_reg    <= cfg_data[NS_W-1:0];
                REG_DIES:      dies_reg      <= cfg_data[ND_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        dw_eff = (die_width_reg == '0) ? DW_W'(1) : die_width_reg;
        if (dies_reg == '0)
            nd_eff = NDC_W'(1);
        else if (int'(dies_reg) > MAX_DIES)
            nd_eff = NDC_W'(MAX_DIES);
        else
            nd_eff = NDC_W'(dies_reg);
        if (strips_reg == '0)
            ns_eff = NS_W'(1);
        else if (int'(strips_reg) > NS_CAP)
            ns_eff = NS_W'(NS_CAP);
        else
            ns_eff = strips_reg;
        period_x     = PER_W'(dw_eff) + PER_W'(gap_x_reg);
        period_y     = PER_W'(dw_eff) + PER_W'(gap_y_reg);
        panel        = 24'(nd_eff) * 24'(dw_eff) + 24'(nd_eff - NDC_W'(1)) * 24'(gap_x_reg);
        half         = panel[HALF_W:1];
        strip_cfg_ok = dw_eff > {1'b0, guard_reg, 1'b0};
        den          = dw_eff - {1'b0, guard_reg, 1'b0};
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign ux_next  = U_W'(x_pos) + U_W'(half);
    assign uy_next  = U_W'(y_pos) + U_W'(half);

    // one quotient bit per stage; remainders for both axes, quotient kept for x only
    always_comb
    begin
        logic           bx;
        logic           by;
        logic [PER_W:0] stx;
        logic [PER_W:0] sty;
        div_in[0].valid = s0_valid_reg;
        div_in[0].ux    = s0_ux_reg;
        div_in[0].uy    = s0_uy_reg;
        div_in[0].rx    = '0;
        div_in[0].ry    = '0;
        div_in[0].qx    = '0;
        for (int k = 1; k < Q_W; k++)
            div_in[k] = div_reg[k-1];
        for (int k = 0; k < Q_W; k++)
        begin
            bx  = div_in[k].ux[U_W-1] ? 1'b0 : div_in[k].ux[Q_W-1-k];
            by  = div_in[k].uy[U_W-1] ? 1'b0 : div_in[k].uy[Q_W-1-k];
            stx = div_step(div_in[k].rx, bx, period_x);
            sty = div_step(div_in[k].ry, by, period_y);
            div_next[k]    = div_in[k];
            div_next[k].rx = stx[PER_W-1:0];
            div_next[k].ry = sty[PER_W-1:0];
            div_next[k].qx = {div_in[k].qx[Q_W-2:0], stx[PER_W]};
        end
    end

    always_comb
    begin
        div_t dv;
        dv             = div_reg[Q_W-1];
        a_next.valid   = dv.valid;
        a_next.dx      = axis_dist(dv.ux, dv.rx, dw_eff, guard_reg);
        a_next.dy      = axis_dist(dv.uy, dv.ry, dw_eff, guard_reg);
        a_next.w       = DIST_W'(dv.rx) - DIST_W'(guard_reg);
        a_next.die     = dv.qx[NDC_W-1:0];
        a_next.strip_en = (a_next.dx > 0) && strip_cfg_ok && (dv.qx < Q_W'(nd_eff));
    end

    always_comb
    begin
        logic signed [SQ_W-1:0] psx;
        logic signed [SQ_W-1:0] psy;
        psx             = a_reg.dx * a_reg.dx;
        psy             = a_reg.dy * a_reg.dy;
        b_next.valid    = a_reg.valid;
        b_next.dx       = a_reg.dx;
        b_next.dy       = a_reg.dy;
        b_next.sqx      = SQ_W'(psx);
        b_next.sqy      = SQ_W'(psy);
        b_next.prod     = PROD_W'(a_reg.w[DW_W-1:0]) * PROD_W'(ns_eff);
        b_next.neg      = !((a_reg.dx > 0) || (a_reg.dy > 0));
        b_next.dmin     = (a_reg.dx < a_reg.dy) ? a_reg.dx : a_reg.dy;
        b_next.die      = a_reg.die;
        b_next.strip_en = a_reg.strip_en;
    end

    always_comb
    begin
        c_next.valid    = b_reg.valid;
        c_next.dx       = b_reg.dx;
        c_next.dy       = b_reg.dy;
        c_next.sum      = b_reg.sqx + b_reg.sqy;
        c_next.prod     = b_reg.prod;
        c_next.neg      = b_reg.neg;
        c_next.dmin     = b_reg.dmin;
        c_next.die      = b_reg.die;
        c_next.strip_en = b_reg.strip_en;
    end

    // one root bit and, in the first stages, one strip quotient bit per stage
    always_comb
    begin
        logic [1:0]       pair;
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic             pbit;
        logic [DW_W:0]    t2;
        it_in[0].valid    = c_reg.valid;
        it_in[0].dx       = c_reg.dx;
        it_in[0].dy       = c_reg.dy;
        it_in[0].sum      = c_reg.sum;
        it_in[0].rem      = '0;
        it_in[0].root     = '0;
        it_in[0].prod     = c_reg.prod;
        it_in[0].sr       = c_reg.prod[PROD_W-1:NS_W];
        it_in[0].sq       = '0;
        it_in[0].neg      = c_reg.neg;
        it_in[0].dmin     = c_reg.dmin;
        it_in[0].die      = c_reg.die;
        it_in[0].strip_en = c_reg.strip_en;
        for (int k = 1; k < IT; k++)
            it_in[k] = it_reg[k-1];
        for (int k = 0; k < IT; k++)
        begin
            it_next[k] = it_in[k];
            pair  = it_in[k].sum[SQ_W-1-2*k -: 2];
            t     = {it_in[k].rem, pair};
            trial = {2'b00, it_in[k].root, 2'b01};
            if (t >= trial)
            begin
                it_next[k].rem  = REM_W'(t - trial);
                it_next[k].root = {it_in[k].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                it_next[k].rem  = REM_W'(t);
                it_next[k].root = {it_in[k].root[ROOT_W-2:0], 1'b0};
            end
            pbit = it_in[k].prod[(k < SD_STEPS) ? (NS_W - 1 - k) : 0];
            t2   = {it_in[k].sr, pbit};
            if (k < SD_STEPS)
            begin
                if (t2 >= {1'b0, den})
                begin
                    it_next[k].sr = DW_W'(t2 - {1'b0, den});
                    it_next[k].sq = {it_in[k].sq[NS_W-2:0], 1'b1};
                end
                else
                begin
                    it_next[k].sr = t2[DW_W-1:0];
                    it_next[k].sq = {it_in[k].sq[NS_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        iter_t        last;
        logic [ROOT_W:0] rootx;
        last  = it_reg[IT-1];
        rootx = {1'b0, last.root};
        if (!last.neg)
            dist_plane_next = last.dmin;
        else if (rootx > (ROOT_W + 1)'(2 ** (DIST_W - 1)))
            dist_plane_next = DIST_W'(DIST_MIN);
        else
            dist_plane_next = DIST_W'((ROOT_W + 1)'(0) - rootx);
        if (last.strip_en)
            strip_index_next = IDX_W'(IDX_W'(last.die) * IDX_W'(ns_eff) + IDX_W'(last.sq));
        else
            strip_index_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int k = 0; k < Q_W; k++)
                div_reg[k].valid <= 1'b0;
            a_reg.valid <= 1'b0;
            b_reg.valid <= 1'b0;
            c_reg.valid <= 1'b0;
            for (int k = 0; k < IT; k++)
                it_reg[k].valid <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= in_valid;
            s0_ux_reg       <= ux_next;
            s0_uy_reg       <= uy_next;
            div_reg         <= div_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            c_reg           <= c_next;
            it_reg          <= it_next;
            out_valid_reg   <= it_reg[IT-1].valid;
            dist_x_reg      <= it_reg[IT-1].dx;
            dist_y_reg      <= it_reg[IT-1].dy;
            dist_plane_reg  <= dist_plane_next;
            strip_index_reg <= strip_index_next;
            strip_valid_reg <= it_reg[IT-1].strip_en;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dist_x      = dist_x_reg;
    assign dist_y      = dist_y_reg;
    assign dist_plane  = dist_plane_reg;
    assign strip_index = strip_index_reg;
    assign strip_valid = strip_valid_reg;

    `SPAA_ASSERT_IMPL(a_strip_needs_dx, out_valid && strip_valid, dist_x > 0, "strip valid with dead x")
    `SPAA_ASSERT_IMPL(a_idx_zero, out_valid && !strip_valid, strip_index == '0, "stray strip index")
    `SPAA_ASSERT_IMPL(a_plane_min, out_valid && (dist_x > 0 || dist_y > 0), dist_plane == dist_x || dist_plane == dist_y, "plane distance not an axis distance")
    `SPAA_ASSERT_NEXT(a_stall_holds, !en, $stable(c_reg.valid) && $stable(a_reg.valid) && $stable(s0_valid_reg), "pipeline moved during stall")
    `SPAA_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, s0_valid_reg, "accepted word not captured")

endmodule
`default_nettype wire

// File: verif/strip_plane_active_area_and_strip_top_tb.sv
`default_nettype none
module strip_plane_active_area_and_strip_top_tb;
    import spaa_pkg::*;

    typedef struct packed {
        logic signed [DIST_W-1:0] dx;
        logic signed [DIST_W-1:0] dy;
        logic signed [DIST_W-1:0] dp;
        logic [IDX_W-1:0]         idx;
        logic                     sv;
    } hit_result_t;

    class hit_scoreboard;
        hit_result_t pending[$];
        int errors;
        longint dw, guard, gap_y, gap_x, ns, nd;

        function new();
            errors = 0;
            dw = DIE_WIDTH_RST;
            guard = GUARD_RST;
            gap_y = GAP_Y_RST;
            gap_x = GAP_X_RST;
            ns = STRIPS_RST;
            nd = DIES_RST;
        endfunction

        function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
            case (r)
                REG_DIE_WIDTH: dw = v[DW_W-1:0];
                REG_GUARD:     guard = v[GAP_W-1:0];
                REG_GAP_Y:     gap_y = v[GAP_W-1:0];
                REG_GAP_X:     gap_x = v[GAP_W-1:0];
                REG_STRIPS:    ns = v[NS_W-1:0];
                REG_DIES:      nd = v[ND_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip20(longint v);
            if (v > 524287) return 524287;
            if (v < -524288) return -524288;
            return v;
        endfunction

        function longint root_floor(longint n);
            longint r;
            r = longint'($sqrt(real'(n)));
            while (r * r > n) r--;
            while ((r + 1) * (r + 1) <= n) r++;
            return r;
        endfunction

        function longint active_depth(longint u, longint w, longint gap);
            longint e;
            if (u < 0) return u;
            e = u % (w + gap);
            if (e > w) return -e;
            if (2 * e > w) e = w - e;
            return e - guard;
        endfunction

        function void note_hit(logic signed [18:0] x, logic signed [18:0] y);
            longint w, n_d, n_s, half, ux, uy, dx, dy, dp, die, s;
            hit_result_t r;
            w = (dw == 0) ? 1 : dw;
            n_d = (nd < 1) ? 1 : (nd > 8 ? 8 : nd);
            n_s = (ns < 1) ? 1 : (ns > 1024 ? 1024 : ns);
            half = (n_d * w + (n_d - 1) * gap_x) / 2;
            ux = longint'(x) + half;
            uy = longint'(y) + half;
            dx = clip20(active_depth(ux, w, gap_x));
            dy = clip20(active_depth(uy, w, gap_y));
            if (dx > 0 || dy > 0)
                dp = (dx < dy) ? dx : dy;
            else
                dp = clip20(-root_floor(dx * dx + dy * dy));
            r.idx = '0;
            r.sv = 1'b0;
            if (dx > 0 && w > 2 * guard)
            begin
                die = ux / (w + gap_x);
                if (die < n_d)
                begin
                    s = ((ux % (w + gap_x) - guard) * n_s) / (w - 2 * guard);
                    r.idx = IDX_W'(die * n_s + s);
                    r.sv = 1'b1;
                end
            end
            r.dx = DIST_W'(dx);
            r.dy = DIST_W'(dy);
            r.dp = DIST_W'(dp);
            pending.push_back(r);
        endfunction

        function void check_word(hit_result_t got);
            hit_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word dist_x=%0d", $time, got.dx);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.dx !== want.dx)
            begin
                $display("%0t: dist_x exp %0d got %0d", $time, want.dx, got.dx);
                errors++;
            end
            if (got.dy !== want.dy)
            begin
                $display("%0t: dist_y exp %0d got %0d", $time, want.dy, got.dy);
                errors++;
            end
            if (got.dp !== want.dp)
            begin
                $display("%0t: dist_plane exp %0d got %0d", $time, want.dp, got.dp);
                errors++;
            end
            if (got.idx !== want.idx)
            begin
                $display("%0t: strip_index exp %0d got %0d", $time, want.idx, got.idx);
                errors++;
            end
            if (got.sv !== want.sv)
            begin
                $display("%0t: strip_valid exp %0d got %0d", $time, want.sv, got.sv);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [18:0] x_pos = '0;
    logic signed [18:0] y_pos = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DIST_W-1:0] dist_x, dist_y, dist_plane;
    logic [IDX_W-1:0] strip_index;
    logic strip_valid;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    hit_scoreboard board = new();
    bit hold_off = 1'b0;

    strip_plane_active_area_and_strip_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .x_pos(x_pos), .y_pos(y_pos),
        .out_valid(out_valid), .out_ready(out_ready),
        .dist_x(dist_x), .dist_y(dist_y), .dist_plane(dist_plane),
        .strip_index(strip_index), .strip_valid(strip_valid),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    // accept and check results
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_word({dist_x, dist_y, dist_plane, strip_index, strip_valid});
    end

    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (out_ready && out_valid)
            begin
                n = gap_len();
                if (n > 0 && $urandom_range(1) == 1)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_hit(logic signed [18:0] x, logic signed [18:0] y, bit no_gap);
        int n;
        n = no_gap ? 0 : gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_pos <= x;
        y_pos <= y;
        do @(posedge clk); while (!in_ready);
        board.note_hit(x, y);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        board.set_reg(r, v);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // near die edges most of the time, anywhere otherwise
    function automatic logic signed [18:0] pick_coord();
        longint w, k, p;
        w = (board.dw == 0) ? 1 : board.dw;
        if ($urandom_range(2) == 0) return 19'($urandom());
        k = $urandom_range(9);
        p = k * (w + board.gap_x) - ((board.nd * w + (board.nd - 1) * board.gap_x) / 2);
        p = p + $signed($urandom_range(2 * board.guard + 40)) - board.guard - 20;
        if ($urandom_range(1)) p = p + w;
        if (p > 262143 || p < -262144) return 19'($urandom());
        return 19'(p);
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_hit(pick_coord(), pick_coord(), 1'b0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_hit(19'sd0, 19'sd0, 1'b0);
        send_hit(-19'sd262144, -19'sd262144, 1'b0);
        send_hit(19'sd262143, 19'sd262143, 1'b0);
        send_hit(-19'sd262144, 19'sd262143, 1'b0);
        send_hit(19'sd262143, -19'sd262144, 1'b0);
        send_hit(-19'sd183501, 19'sd0, 1'b0);
        send_hit(-19'sd182504, -19'sd182504, 1'b0);
        send_hit(-19'sd90000, -19'sd90000, 1'b0);
        send_hit(-19'sd91700, -19'sd91700, 1'b0);
        send_hit(19'sd183500, 19'sd100, 1'b0);
        send_hit(-19'sd1, 19'sd1, 1'b0);
        random_phase(120);
        // back-pressure stretch: fill pipeline while the sink holds off
        hold_off = 1'b1;
        for (int i = 0; i < 80; i++)
            send_hit(19'($urandom()), 19'($urandom()), 1'b1);
        drain();
        write_reg(REG_DIE_WIDTH, 18'd0);
        write_reg(REG_GUARD, 18'd0);
        write_reg(REG_GAP_X, 18'd65535);
        write_reg(REG_GAP_Y, 18'd65535);
        write_reg(REG_STRIPS, 18'd0);
        write_reg(REG_DIES, 18'd0);
        end_writes();
        send_hit(19'sd0, 19'sd0, 1'b0);
        random_phase(50);
        drain();
        write_reg(REG_DIE_WIDTH, 18'd262143);
        write_reg(REG_GUARD, 18'd65535);
        write_reg(REG_GAP_X, 18'd0);
        write_reg(REG_GAP_Y, 18'd0);
        write_reg(REG_STRIPS, 18'd2047);
        write_reg(REG_DIES, 18'd15);
        end_writes();
        random_phase(60);
        drain();
        write_reg(REG_DIE_WIDTH, 18'd20000);
        write_reg(REG_GUARD, 18'd1000);
        write_reg(REG_GAP_X, 18'd300);
        write_reg(REG_GAP_Y, 18'd700);
        write_reg(REG_STRIPS, 18'd1024);
        write_reg(REG_DIES, 18'd8);
        end_writes();
        random_phase(100);
        drain();
        write_reg(REG_DIE_WIDTH, 18'd1500);
        write_reg(REG_GUARD, 18'd800);
        write_reg(REG_STRIPS, 18'd1);
        write_reg(REG_DIES, 18'd1);
        end_writes();
        random_phase(40);
        drain();
        write_reg(REG_DIE_WIDTH, 18'd30001);
        write_reg(REG_GUARD, 18'd17);
        write_reg(REG_GAP_X, 18'd3);
        write_reg(REG_GAP_Y, 18'd9);
        write_reg(REG_STRIPS, 18'd777);
        write_reg(REG_DIES, 18'd5);
        end_writes();
        random_phase(100);
        drain();
        repeat (60) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
